// File: hdl/sscvl_pkg.sv
// ============================================================================
// sscvl_pkg: constants for the stereo soft clipper and volume limiter
// Fixed-point formats, per-mode coefficient tables and register indexes.
// ============================================================================
package sscvl_pkg;

  localparam int unsigned FRAC_BITS = 16;

  localparam logic [31:0] FULL_SCALE = 32'd32767;

  localparam logic [16:0] ALPHA_0 = 17'd95027;
  localparam logic [16:0] ALPHA_1 = 17'd70124;
  localparam logic [16:0] ALPHA_2 = 17'd49152;
  localparam logic [16:0] ALPHA_3 = 17'd34734;

  localparam logic [17:0] COMP_0 = 18'd77884;
  localparam logic [17:0] COMP_1 = 18'd92453;
  localparam logic [17:0] COMP_2 = 18'd131072;
  localparam logic [17:0] COMP_3 = 18'd185479;

  // Clipper knee, alpha * full scale, in input units.
  localparam logic [63:0] DIV_WIDE_0 = 64'(ALPHA_0) * 64'(FULL_SCALE);
  localparam logic [63:0] DIV_WIDE_1 = 64'(ALPHA_1) * 64'(FULL_SCALE);
  localparam logic [63:0] DIV_WIDE_2 = 64'(ALPHA_2) * 64'(FULL_SCALE);
  localparam logic [63:0] DIV_WIDE_3 = 64'(ALPHA_3) * 64'(FULL_SCALE);

  // Reciprocals of the knee, scaled by 2^62, for the normalising division.
  localparam logic [63:0] RECIP_WIDE_0 = (64'd1 << 62) / DIV_WIDE_0;
  localparam logic [63:0] RECIP_WIDE_1 = (64'd1 << 62) / DIV_WIDE_1;
  localparam logic [63:0] RECIP_WIDE_2 = (64'd1 << 62) / DIV_WIDE_2;
  localparam logic [63:0] RECIP_WIDE_3 = (64'd1 << 62) / DIV_WIDE_3;

  localparam logic [29:0] Y_SAT       = 30'd715827882;
  localparam logic [31:0] THIRD_RECIP = 32'hAAAA_AAAB;

  localparam logic [32:0] CLIP_HI     = 33'd32767 << FRAC_BITS;
  localparam logic [33:0] CLIP_LO_MAG = 34'd32768 << FRAC_BITS;

  localparam logic [1:0] REG_SOFTCLIP_MODE = 2'd0;
  localparam logic [1:0] REG_GAIN_COMP     = 2'd1;
  localparam logic [1:0] REG_MASTER_GAIN   = 2'd2;

  localparam logic [16:0] MASTER_GAIN_RESET = 17'd65536;

  function automatic logic [31:0] knee_of(logic [1:0] idx);
    logic [31:0] r;
    case (idx)
      2'd0:    r = DIV_WIDE_0[31:0];
      2'd1:    r = DIV_WIDE_1[31:0];
      2'd2:    r = DIV_WIDE_2[31:0];
      default: r = DIV_WIDE_3[31:0];
    endcase
    return r;
  endfunction

  function automatic logic [31:0] recip_of(logic [1:0] idx);
    logic [31:0] r;
    case (idx)
      2'd0:    r = RECIP_WIDE_0[31:0];
      2'd1:    r = RECIP_WIDE_1[31:0];
      2'd2:    r = RECIP_WIDE_2[31:0];
      default: r = RECIP_WIDE_3[31:0];
    endcase
    return r;
  endfunction

  function automatic logic [17:0] comp_of(logic [1:0] idx);
    logic [17:0] r;
    case (idx)
      2'd0:    r = COMP_0;
      2'd1:    r = COMP_1;
      2'd2:    r = COMP_2;
      default: r = COMP_3;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/stereo_softclip_volume_limiter.sv
// ============================================================================
// stereo_softclip_volume_limiter: cubic soft clipper, master gain, hard limit
// Processes one stereo pair per transfer through a shared 32x32 multiplier.
// ============================================================================
// One sample pair is taken at a time; the two channels pass in turn through a
// single registered 32x32 multiplier under a small sequencer. In bypass each
// channel goes straight to the master gain product. With the soft clipper each
// channel runs a chain of dependent products: reciprocal, remainder check,
// square, cube, division by three, output scaling, compensation and master
// gain; a channel driven past the knee skips from the reciprocal to output
// scaling, and compensation runs only with gain compensation on. A finished
// result waits in an output register, and the block returns to accept the
// next pair once that register is free. Configuration registers are written
// through the cfg channel, which is always ready; write them only while the
// block is idle.
module stereo_softclip_volume_limiter import sscvl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // left_sample [31:0], right_sample [63:32]
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // left_out [15:0], right_out [31:16], clipped [32], peak_level [64:33]
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOAD = 4'd1;
  localparam logic [3:0] ST_RCP  = 4'd2;
  localparam logic [3:0] ST_QD   = 4'd3;
  localparam logic [3:0] ST_FIX  = 4'd4;
  localparam logic [3:0] ST_X2   = 4'd5;
  localparam logic [3:0] ST_X3   = 4'd6;
  localparam logic [3:0] ST_DIV3 = 4'd7;
  localparam logic [3:0] ST_Y    = 4'd8;
  localparam logic [3:0] ST_YD   = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;
  localparam logic [3:0] ST_CMP  = 4'd11;
  localparam logic [3:0] ST_GAIN = 4'd12;
  localparam logic [3:0] ST_CLIP = 4'd13;
  localparam logic [3:0] ST_PEAK = 4'd14;
  localparam logic [3:0] ST_DONE = 4'd15;

  logic [3:0]  state_q, state_d;
  logic        ch_q, ch_d;
  logic [2:0]  mode_q;
  logic        gcomp_q;
  logic [16:0] gain_q;
  logic [31:0] l_q, r_q;
  logic        last_q;
  logic        neg_q, neg_d;
  logic [31:0] mag_q, mag_d;
  logic        sat_q, sat_d;
  logic [29:0] q0_q, q0_d;
  logic [29:0] x_q, x_d;
  logic [29:0] y_q, y_d;
  logic [63:0] p_q, p_d;
  logic [31:0] res_q, res_d;
  logic [15:0] lres_q, lres_d;
  logic [15:0] rres_q, rres_d;
  logic [31:0] peak_q, peak_d;
  logic        clip_q, clip_d;
  logic        out_valid_q;
  logic [71:0] out_data_q;
  logic        out_last_q;

  logic        accept_s;
  logic        out_load_s;
  logic        soft_en_s;
  logic [1:0]  mode_idx_s;
  logic [31:0] knee_s;
  logic [31:0] recip_s;
  logic [17:0] comp_s;
  logic [31:0] sample_s;
  logic [33:0] rem_s;
  logic [32:0] gain_hi_s;
  logic [33:0] ceil_s;
  logic [31:0] pvalue_s;
  logic [31:0] opa_s, opb_s;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept_s      = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  assign soft_en_s  = (mode_q inside {[3'd1:3'd4]});
  assign mode_idx_s = 2'(mode_q - 3'd1);
  assign knee_s     = knee_of(mode_idx_s);
  assign recip_s    = recip_of(mode_idx_s);
  assign comp_s     = comp_of(mode_idx_s);

  assign sample_s  = ch_q ? r_q : l_q;
  assign rem_s     = {mag_q[3:0], 30'd0} - p_q[33:0];
  assign gain_hi_s = p_q[48:16];
  assign ceil_s    = {1'b0, gain_hi_s} + {33'd0, (|p_q[15:0])};
  assign pvalue_s  = neg_q ? (~res_q + 32'd1) : res_q;

  assign p_d = 64'(opa_s) * 64'(opb_s);

  always_comb begin
    state_d    = state_q;
    ch_d       = ch_q;
    neg_d      = neg_q;
    mag_d      = mag_q;
    sat_d      = sat_q;
    q0_d       = q0_q;
    x_d        = x_q;
    y_d        = y_q;
    res_d      = res_q;
    lres_d     = lres_q;
    rres_d     = rres_q;
    peak_d     = peak_q;
    clip_d     = clip_q;
    opa_s      = 32'd0;
    opb_s      = 32'd0;
    out_load_s = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept_s) begin
          state_d = ST_LOAD;
          ch_d    = 1'b0;
        end
      end
      ST_LOAD: begin
        neg_d   = sample_s[31];
        mag_d   = sample_s[31] ? (~sample_s + 32'd1) : sample_s;
        state_d = soft_en_s ? ST_RCP : ST_GAIN;
      end
      ST_RCP: begin
        opa_s   = mag_q;
        opb_s   = recip_s;
        sat_d   = (mag_q >= knee_s);
        state_d = ST_QD;
      end
      ST_QD: begin
        if (sat_q) begin
          y_d     = Y_SAT;
          state_d = ST_YD;
        end else begin
          q0_d    = p_q[61:32];
          opa_s   = {2'd0, p_q[61:32]};
          opb_s   = knee_s;
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        x_d     = (rem_s >= {2'd0, knee_s}) ? (q0_q + 30'd1) : q0_q;
        state_d = ST_X2;
      end
      ST_X2: begin
        opa_s   = {2'd0, x_q};
        opb_s   = {2'd0, x_q};
        state_d = ST_X3;
      end
      ST_X3: begin
        opa_s   = {2'd0, p_q[59:30]};
        opb_s   = {2'd0, x_q};
        state_d = ST_DIV3;
      end
      ST_DIV3: begin
        opa_s   = {2'd0, p_q[59:30]};
        opb_s   = THIRD_RECIP;
        state_d = ST_Y;
      end
      ST_Y: begin
        y_d     = x_q - p_q[62:33];
        state_d = ST_YD;
      end
      ST_YD: begin
        opa_s   = {2'd0, y_q};
        opb_s   = knee_s;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (gcomp_q) begin
          opa_s   = p_q[61:30];
          opb_s   = {14'd0, comp_s};
          state_d = ST_CMP;
        end else begin
          mag_d   = p_q[61:30];
          state_d = ST_GAIN;
        end
      end
      ST_CMP: begin
        mag_d   = p_q[47:16];
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        opa_s   = mag_q;
        opb_s   = {15'd0, gain_q};
        state_d = ST_CLIP;
      end
      ST_CLIP: begin
        if (!neg_q) begin
          if (gain_hi_s > CLIP_HI) begin
            res_d  = CLIP_HI[31:0];
            clip_d = 1'b1;
          end else begin
            res_d = gain_hi_s[31:0];
          end
        end else begin
          if (ceil_s > CLIP_LO_MAG) begin
            res_d  = CLIP_LO_MAG[31:0];
            clip_d = 1'b1;
          end else begin
            res_d = ceil_s[31:0];
          end
        end
        state_d = ST_PEAK;
      end
      ST_PEAK: begin
        if (ch_q) begin
          rres_d  = pvalue_s[FRAC_BITS+15:FRAC_BITS];
          state_d = ST_DONE;
        end else begin
          lres_d  = pvalue_s[FRAC_BITS+15:FRAC_BITS];
          ch_d    = 1'b1;
          state_d = ST_LOAD;
        end
        if (res_q > peak_q) begin
          peak_d = res_q;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load_s = 1'b1;
          state_d    = ST_IDLE;
          if (last_q) begin
            peak_d = 32'd0;
            clip_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= 1'b0;
      peak_q      <= 32'd0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= 3'd0;
      gcomp_q     <= 1'b0;
      gain_q      <= MASTER_GAIN_RESET;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      peak_q  <= peak_d;
      clip_q  <= clip_d;
      if (out_load_s) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_SOFTCLIP_MODE: mode_q  <= cfg_data_i[2:0];
          REG_GAIN_COMP:     gcomp_q <= cfg_data_i[0];
          REG_MASTER_GAIN:   gain_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_s) begin
      l_q    <= s_axis_tdata[31:0];
      r_q    <= s_axis_tdata[63:32];
      last_q <= s_axis_tlast;
    end
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    sat_q  <= sat_d;
    q0_q   <= q0_d;
    x_q    <= x_d;
    y_q    <= y_d;
    p_q    <= p_d;
    res_q  <= res_d;
    lres_q <= lres_d;
    rres_q <= rres_d;
    if (out_load_s) begin
      out_data_q <= {7'd0, peak_q, clip_q, rres_q, lres_q};
      out_last_q <= last_q;
    end
  end

  a_start_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_s |=> (state_q == ST_LOAD) && !ch_q)
    else $error("pair did not start with the left channel");

  a_cube_below_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Y) |-> (x_q >= p_q[62:33]))
    else $error("cubic term exceeds x");

  a_limit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PEAK) |-> (res_q <= CLIP_LO_MAG[31:0]))
    else $error("limited magnitude out of range");

  a_buffer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load_s && last_q) |=> (peak_q == 32'd0) && !clip_q)
    else $error("peak or clip flag not cleared at end of buffer");

endmodule
